>>> rtl/cesd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cesd_pkg
// shared types, character codes and digit helpers for the escape decoder
// ----------------------------------------------------------------------------
package cesd_pkg;

  // character codes
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X         = 8'h78;
  localparam logic [7:0] HEX_EMPTY_VAL  = 8'hFF;
  // upper five bits shared by '0'..'7'
  localparam logic [4:0] OCT_PREFIX     = 5'b00110;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       last;
  } result_t;

  // results of one input item, handed from decoder to output buffer
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } dec_out_t;

  // hex digit value, msb set when the byte is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] res;
    res = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      res = {1'b1, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      res = {1'b1, b[3:0] + 4'd9};
    end
    return res;
  endfunction

  // control code for the simple escapes, other bytes pass through
  function automatic logic [7:0] simple_escape(input logic [7:0] b);
    logic [7:0] res;
    res = b;
    case (b)
      8'h61:   res = 8'h07;  // a
      8'h62:   res = 8'h08;  // b
      8'h66:   res = 8'h0C;  // f
      8'h6E:   res = 8'h0A;  // n
      8'h72:   res = 8'h0D;  // r
      8'h74:   res = 8'h09;  // t
      8'h76:   res = 8'h0B;  // v
      default: res = b;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/c_escape_sequence_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_core
// decodes C-style backslash escapes in a byte stream, one byte per item
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while in_ready_o is high. Its decode is
// done in the same cycle from the escape state register and yields zero, one
// or two result items, which go into a three-entry result queue whose head
// drives the output. in_ready_o depends only on the queue fill (at most one
// entry waiting), so there is no combinational path from out_ready_i to
// in_ready_o. With a ready consumer a byte giving one result sustains 1 item
// per cycle; a byte giving two results (a hex or octal escape closed by a
// following byte that is not a backslash) holds off input while the queue
// drains. Results are registered in the queue before they reach the output.
// Simple escapes a b f n r t v map to control codes, \x takes one or two hex
// digits (none gives 0xff), \ooo takes up to three octal digits truncated to
// 8 bits, any other escaped byte passes through. The byte that ends a hex or
// octal escape is then decoded as ordinary input. A backslash as the final
// byte is dropped, and a final byte with no decoded result gives an end
// marker with byte_valid_o low and out_byte_o zero.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input channel
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  // output channel
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            out_end_o
);

  logic               accept;
  cesd_pkg::dec_out_t dec;
  cesd_pkg::result_t  head;

  // item taken on valid and ready
  assign accept = in_valid_i && in_ready_o;

  // escape state and single-pass decode
  cesd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .dec_o     (dec)
  );

  // result queue, parts input and output handshakes
  cesd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .dec_i       (dec),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  // head entry fields to ports
  assign out_byte_o   = head.data;
  assign byte_valid_o = head.vld;
  assign out_end_o    = head.last;

endmodule
`default_nettype wire

>>> rtl/cesd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cesd_decode
// escape state register and single-pass decode of one byte into up to two
// result items
// ----------------------------------------------------------------------------
module cesd_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              in_last_i,
  output cesd_pkg::dec_out_t     dec_o
);

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_HEX0  = 3'd2,
    MODE_HEX1  = 3'd3,
    MODE_OCT1  = 3'd4,
    MODE_OCT2  = 3'd5
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [7:0] part_q, part_d;

  always_comb begin
    logic              as_plain;
    logic [1:0]        n;
    cesd_pkg::result_t res [2];
    cesd_pkg::result_t nr;
    logic [4:0]        hx;
    logic              is_oct;

    as_plain = 1'b0;
    n        = 2'd0;
    res[0]   = '0;
    res[1]   = '0;
    mode_d   = mode_q;
    part_d   = part_q;
    hx       = cesd_pkg::hex_digit(in_byte_i);
    is_oct   = (in_byte_i[7:3] == cesd_pkg::OCT_PREFIX);
    nr       = '0;
    nr.vld   = 1'b1;

    case (mode_q)
      MODE_ESC: begin
        if (in_byte_i == cesd_pkg::CHAR_X) begin
          mode_d = MODE_HEX0;
          part_d = '0;
        end else if (is_oct) begin
          mode_d = MODE_OCT1;
          part_d = {5'd0, in_byte_i[2:0]};
        end else begin
          nr.data = cesd_pkg::simple_escape(in_byte_i);
          res[n[0]] = nr;
          n = n + 2'd1;
          mode_d = MODE_PLAIN;
        end
      end
      MODE_HEX0: begin
        if (hx[4]) begin
          mode_d = MODE_HEX1;
          part_d = {4'd0, hx[3:0]};
        end else begin
          nr.data = cesd_pkg::HEX_EMPTY_VAL;
          res[n[0]] = nr;
          n = n + 2'd1;
          mode_d = MODE_PLAIN;
          as_plain = 1'b1;
        end
      end
      MODE_HEX1: begin
        if (hx[4]) begin
          nr.data = {part_q[3:0], hx[3:0]};
        end else begin
          nr.data = part_q;
          as_plain = 1'b1;
        end
        res[n[0]] = nr;
        n = n + 2'd1;
        mode_d = MODE_PLAIN;
      end
      MODE_OCT1: begin
        if (is_oct) begin
          part_d = {part_q[4:0], in_byte_i[2:0]};
          mode_d = MODE_OCT2;
        end else begin
          nr.data = part_q;
          res[n[0]] = nr;
          n = n + 2'd1;
          mode_d = MODE_PLAIN;
          as_plain = 1'b1;
        end
      end
      MODE_OCT2: begin
        if (is_oct) begin
          nr.data = {part_q[4:0], in_byte_i[2:0]};
        end else begin
          nr.data = part_q;
          as_plain = 1'b1;
        end
        res[n[0]] = nr;
        n = n + 2'd1;
        mode_d = MODE_PLAIN;
      end
      default: begin
        mode_d = MODE_PLAIN;
        as_plain = 1'b1;
      end
    endcase

    if (as_plain) begin
      if (in_byte_i == cesd_pkg::CHAR_BACKSLASH) begin
        mode_d = MODE_ESC;
      end else begin
        nr.data = in_byte_i;
        res[n[0]] = nr;
        n = n + 2'd1;
      end
    end

    if (in_last_i) begin
      // end of string closes a pending escape
      if (mode_d == MODE_HEX0) begin
        nr.data = cesd_pkg::HEX_EMPTY_VAL;
        res[n[0]] = nr;
        n = n + 2'd1;
      end else if (mode_d == MODE_HEX1 || mode_d == MODE_OCT1 || mode_d == MODE_OCT2) begin
        nr.data = part_d;
        res[n[0]] = nr;
        n = n + 2'd1;
      end
      if (n == 2'd0) begin
        res[0] = '0;
        n = 2'd1;
      end
      if (n == 2'd1) begin
        res[0].last = 1'b1;
      end else begin
        res[1].last = 1'b1;
      end
      mode_d = MODE_PLAIN;
      part_d = '0;
    end

    dec_o.cnt = n;
    dec_o.r0  = res[0];
    dec_o.r1  = res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      part_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      part_q <= part_d;
    end
  end

  // escape state clears after the final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && in_last_i |=> mode_q == MODE_PLAIN && part_q == 8'd0)
    else $error("escape state not cleared after final byte");

  // final byte always yields at least one item carrying the end flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_last_i |-> dec_o.cnt != 2'd0 && (dec_o.r0.last || dec_o.r1.last))
    else $error("final byte without end item");

  // state only moves on an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(mode_q) && $stable(part_q))
    else $error("escape state changed without an item");

endmodule
`default_nettype wire

>>> rtl/cesd_outbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cesd_outbuf
// three-entry result queue; head entry drives the output channel
// ----------------------------------------------------------------------------
module cesd_outbuf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire cesd_pkg::dec_out_t dec_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cesd_pkg::result_t      head_o
);

  cesd_pkg::result_t slot_q [3];
  cesd_pkg::result_t slot_d [3];
  logic [1:0]        cnt_q, cnt_d;
  logic              pop;
  logic [1:0]        base;
  logic [1:0]        push_n;

  assign ready_o     = (cnt_q <= 2'd1);
  assign out_valid_o = (cnt_q != 2'd0);
  assign head_o      = slot_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign push_n      = push_i ? dec_i.cnt : 2'd0;
  assign base        = cnt_q - {1'b0, pop};

  always_comb begin
    slot_d = slot_q;
    if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
    end
    for (int i = 0; i < 3; i++) begin
      if (push_n != 2'd0 && base == 2'(i)) slot_d[i] = dec_i.r0;
      if (push_n == 2'd2 && base + 2'd1 == 2'(i)) slot_d[i] = dec_i.r1;
    end
    cnt_d = base + push_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  // a push never exceeds the free entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ({1'b0, base} + {1'b0, push_n}) <= 3'd3)
    else $error("result queue overflow");

  // two results into one waiting entry fill the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && dec_i.cnt == 2'd2 && cnt_q == 2'd1 && !pop |=> cnt_q == 2'd3)
    else $error("queue count wrong after double push");

  // occupancy is stable with no push and no pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_i || dec_i.cnt == 2'd0) && !pop |=> $stable(cnt_q))
    else $error("queue count moved while idle");

endmodule
`default_nettype wire
